// ===== hdl/bmseq_pkg.sv =====
package bmseq_pkg;

    localparam int MELODY_COUNT_DEF = 32;
    localparam int STEP_DEPTH_DEF   = 256;

    localparam logic [15:0] END_MARK       = 16'hFFFF;
    localparam logic [7:0]  PRESCALE_RESET = 8'd10;

    typedef enum logic [2:0] {
        OP_TICK       = 3'd0,
        OP_PLAY       = 3'd1,
        OP_SET_SILENT = 3'd2,
        OP_LOAD_STEP  = 3'd3,
        OP_LOAD_DIR   = 3'd4
    } t_op;

    typedef struct packed {
        logic        power;
        logic [15:0] tone;
        logic [15:0] duration;
    } t_step;

    typedef struct packed {
        logic       silent_ok;
        logic [7:0] start;
    } t_dir;

endpackage

// ===== hdl/buzzer_melody_sequencer.sv =====
// Melody player for a buzzer. Steps (power, tone divider, duration) and a melody
// directory (start address, silent-mode permission) are loaded through input
// transactions; tick transactions advance the prescaler and the step timer and
// fetch the next step when the timer runs out, unless silent mode is on and the
// melody lacks permission; a duration of 0xFFFF ends the melody. Every input
// transaction gives one result transaction with the player state after it. One
// transaction is accepted per clock cycle unless the output stalls. Memories are
// read on acceptance; one update stage forwards its next state into the next
// read address and the output register. Neither memory is cleared after reset:
// entries must be loaded before use. The user must write tick_prescale through
// i_cfg_we/i_cfg_wdata while the block is idle; the block does not enforce it.
module buzzer_melody_sequencer
    import bmseq_pkg::*;
#(
    parameter int MELODY_COUNT = MELODY_COUNT_DEF,
    parameter int STEP_DEPTH   = STEP_DEPTH_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,

    input  logic        i_cfg_we,
    input  logic [7:0]  i_cfg_wdata,

    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [2:0]  i_operation,
    input  logic [4:0]  i_melody_id,
    input  logic        i_silent_on,
    input  logic [7:0]  i_table_address,
    input  logic        i_step_power,
    input  logic [15:0] i_step_tone,
    input  logic [15:0] i_step_duration,
    input  logic        i_melody_silent_allowed,

    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic        o_buzzer_on,
    output logic [15:0] o_tone_divider,
    output logic        o_sound_start,
    output logic        o_sound_stop,
    output logic        o_playing,
    output logic        o_silent_status
);

    localparam int SA_W = $clog2(STEP_DEPTH);
    localparam int DA_W = $clog2(MELODY_COUNT);

    function automatic logic [SA_W-1:0] step_mod(input logic [8:0] v);
        logic [8:0] r;
        r = v;
        for (int k = 8; k >= 0; k--) begin
            if ((STEP_DEPTH << k) <= 511 && 32'(r) >= (STEP_DEPTH << k)) begin
                r = r - 9'(STEP_DEPTH << k);
            end
        end
        return SA_W'(r);
    endfunction

    function automatic logic [DA_W-1:0] dir_mod(input logic [4:0] v);
        logic [4:0] r;
        r = v;
        for (int k = 4; k >= 0; k--) begin
            if ((MELODY_COUNT << k) <= 31 && 32'(r) >= (MELODY_COUNT << k)) begin
                r = r - 5'(MELODY_COUNT << k);
            end
        end
        return DA_W'(r);
    endfunction

    // memories
    t_step r_step_mem [STEP_DEPTH];
    t_dir  r_dir_mem  [MELODY_COUNT];
    t_step r_step_rd;
    t_dir  r_dir_rd;

    // configuration
    logic [7:0] r_tick_prescale;

    // player state
    logic [7:0]  r_pc,       n_pc;
    logic [15:0] r_rt,       n_rt;
    logic [7:0]  r_off,      n_off;
    logic [4:0]  r_cur,      n_cur;
    logic        r_power,    n_power;
    logic [15:0] r_tone,     n_tone;
    logic        r_silent,   n_silent;
    logic [7:0]  r_cur_start, n_cur_start;
    logic        r_cur_ok,   n_cur_ok;
    logic        n_start;
    logic        n_stop;

    // read/update stage
    logic        r_s1_valid;
    logic [2:0]  r_s1_op;
    logic [4:0]  r_s1_id;
    logic        r_s1_silent_on;
    logic [7:0]  r_s1_addr;
    logic        r_s1_allowed;

    // output register
    logic        r_out_valid;
    logic        r_out_power;
    logic [15:0] r_out_tone;
    logic        r_out_start;
    logic        r_out_stop;
    logic        r_out_playing;
    logic        r_out_silent;

    logic s1_adv;
    logic s1_fire;
    logic in_acc;

    assign s1_adv     = !r_out_valid || i_out_ready;
    assign s1_fire    = r_s1_valid && s1_adv;
    assign o_in_ready = !r_s1_valid || s1_adv;
    assign in_acc     = i_in_valid && o_in_ready;

    always_comb begin
        logic [7:0]  pc_inc;
        logic [15:0] rt_tmp;
        pc_inc      = r_pc + 8'd1;
        rt_tmp      = r_rt;
        n_pc        = r_pc;
        n_rt        = r_rt;
        n_off       = r_off;
        n_cur       = r_cur;
        n_power     = r_power;
        n_tone      = r_tone;
        n_silent    = r_silent;
        n_cur_start = r_cur_start;
        n_cur_ok    = r_cur_ok;
        n_start     = 1'b0;
        n_stop      = 1'b0;
        if (s1_fire) begin
            unique case (t_op'(r_s1_op))
                OP_TICK: begin
                    n_pc = pc_inc;
                    if (pc_inc >= r_tick_prescale) begin
                        n_pc = 8'd0;
                        if (r_rt != 16'd0) begin
                            rt_tmp = r_rt - 16'd1;
                        end
                    end
                    n_rt = rt_tmp;
                    if (r_cur == 5'd0) begin
                        n_stop  = 1'b1;
                        n_rt    = 16'd0;
                        n_off   = 8'd0;
                        n_power = 1'b0;
                        n_tone  = 16'd0;
                    end else if ((!r_silent || r_cur_ok) && rt_tmp == 16'd0) begin
                        n_power = r_step_rd.power;
                        n_tone  = r_step_rd.tone;
                        n_rt    = r_step_rd.duration;
                        n_off   = r_off + 8'd1;
                        n_start = 1'b1;
                        if (r_step_rd.duration == END_MARK) begin
                            n_cur = 5'd0;
                        end
                    end
                end
                OP_PLAY: begin
                    if (!r_silent || r_dir_rd.silent_ok) begin
                        n_cur       = r_s1_id;
                        n_off       = 8'd0;
                        n_rt        = 16'd0;
                        n_cur_start = r_dir_rd.start;
                        n_cur_ok    = r_dir_rd.silent_ok;
                    end
                end
                OP_SET_SILENT: begin
                    n_silent = r_s1_silent_on;
                end
                OP_LOAD_DIR: begin
                    // keep the cached entry of the selected melody coherent
                    if (dir_mod(r_s1_id) == dir_mod(r_cur)) begin
                        n_cur_start = r_s1_addr;
                        n_cur_ok    = r_s1_allowed;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    // step store: write on load, read with the forwarded offset
    always_ff @(posedge i_clk) begin
        if (in_acc && i_operation == OP_LOAD_STEP) begin
            r_step_mem[step_mod({1'b0, i_table_address})] <=
                '{power: i_step_power, tone: i_step_tone, duration: i_step_duration};
        end
        if (in_acc && i_operation == OP_TICK) begin
            r_step_rd <= r_step_mem[step_mod({1'b0, n_cur_start} + {1'b0, n_off})];
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc && i_operation == OP_LOAD_DIR) begin
            r_dir_mem[dir_mod(i_melody_id)] <=
                '{silent_ok: i_melody_silent_allowed, start: i_table_address};
        end
        if (in_acc && i_operation == OP_PLAY) begin
            r_dir_rd <= r_dir_mem[dir_mod(i_melody_id)];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tick_prescale <= PRESCALE_RESET;
            r_pc            <= '0;
            r_rt            <= '0;
            r_off           <= '0;
            r_cur           <= '0;
            r_power         <= 1'b0;
            r_tone          <= '0;
            r_silent        <= 1'b0;
            r_cur_start     <= '0;
            r_cur_ok        <= 1'b0;
            r_s1_valid      <= 1'b0;
            r_out_valid     <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_tick_prescale <= i_cfg_wdata;
            end
            r_pc        <= n_pc;
            r_rt        <= n_rt;
            r_off       <= n_off;
            r_cur       <= n_cur;
            r_power     <= n_power;
            r_tone      <= n_tone;
            r_silent    <= n_silent;
            r_cur_start <= n_cur_start;
            r_cur_ok    <= n_cur_ok;
            if (o_in_ready) begin
                r_s1_valid <= i_in_valid;
            end
            if (s1_fire) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_s1_op        <= i_operation;
            r_s1_id        <= i_melody_id;
            r_s1_silent_on <= i_silent_on;
            r_s1_addr      <= i_table_address;
            r_s1_allowed   <= i_melody_silent_allowed;
        end
        if (s1_fire) begin
            r_out_power   <= n_power;
            r_out_tone    <= n_tone;
            r_out_start   <= n_start;
            r_out_stop    <= n_stop;
            r_out_playing <= (n_cur != 5'd0);
            r_out_silent  <= n_silent;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_buzzer_on     = r_out_power;
    assign o_tone_divider  = r_out_tone;
    assign o_sound_start   = r_out_start;
    assign o_sound_stop    = r_out_stop;
    assign o_playing       = r_out_playing;
    assign o_silent_status = r_out_silent;

`ifndef SYNTHESIS
    a_start_stop_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> !(o_sound_start && o_sound_stop))
        else $error("start and stop pulse in one transaction");

    a_stop_silent_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_sound_stop |-> !o_buzzer_on && o_tone_divider == 16'd0
            && !o_playing)
        else $error("stop pulse with live step state");

    a_s1_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s1_valid && !s1_adv |=> r_s1_valid && $stable(r_s1_op) && $stable(r_s1_id))
        else $error("stalled update stage lost its transaction");

    a_idle_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s1_fire && r_s1_op == OP_TICK && r_cur == 5'd0 |=> r_rt == 16'd0 && r_off == 8'd0)
        else $error("idle tick did not clear player state");
`endif

endmodule

// ===== tb/tb_buzzer_melody_sequencer.sv =====
module tb_buzzer_melody_sequencer;
    import bmseq_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int WATCHDOG_LIMIT = 5000;
    localparam int LONG_HOLD      = 300;
    localparam int SETTLE         = 6;

    localparam logic [2:0] OP_RSVD5 = 3'd5;
    localparam logic [2:0] OP_RSVD6 = 3'd6;
    localparam logic [2:0] OP_RSVD7 = 3'd7;

    typedef struct packed {
        logic [2:0]  op;
        logic [4:0]  id;
        logic        silent;
        logic [7:0]  addr;
        logic        power;
        logic [15:0] tone;
        logic [15:0] dur;
        logic        sil_ok;
    } t_cmd;

    typedef struct packed {
        logic        buzz;
        logic [15:0] tone;
        logic        start;
        logic        stop;
        logic        playing;
        logic        silent;
    } t_resp;

    typedef struct packed {
        t_cmd  cmd;
        logic  typed;
        t_resp exp;
    } t_row;

    logic        clk       = 1'b0;
    logic        rst_n     = 1'b0;
    logic        cfg_we    = 1'b0;
    logic [7:0]  cfg_wdata = 8'd0;
    logic        in_valid  = 1'b0;
    logic        out_ready = 1'b0;
    t_cmd        cmd       = '0;
    logic        cmd_typed = 1'b0;
    t_resp       cmd_exp   = '0;

    logic        o_in_ready;
    logic        o_out_valid;
    logic        o_buzzer_on;
    logic [15:0] o_tone_divider;
    logic        o_sound_start;
    logic        o_sound_stop;
    logic        o_playing;
    logic        o_silent_status;

    // predictor state
    logic [7:0]  tick_div;
    logic [7:0]  pre_cnt;
    logic [15:0] time_left;
    logic [7:0]  step_ofs;
    logic [4:0]  cur_mel;
    logic        buzz_now;
    logic [15:0] tone_now;
    logic        silent_now;
    t_step       step_mem [STEP_DEPTH_DEF];
    t_dir        dir_mem  [MELODY_COUNT_DEF];

    t_resp pending_outputs [$];
    t_row  directed_rows [$];
    int    errors       = 0;
    int    stall_cycles = 0;
    bit    hold_req     = 1'b0;
    bit    tx_idle_en   = 1'b1;
    bit    rx_idle_en   = 1'b1;

    buzzer_melody_sequencer dut (
        .i_clk                   (clk),
        .i_rst_n                 (rst_n),
        .i_cfg_we                (cfg_we),
        .i_cfg_wdata             (cfg_wdata),
        .i_in_valid              (in_valid),
        .o_in_ready              (o_in_ready),
        .i_operation             (cmd.op),
        .i_melody_id             (cmd.id),
        .i_silent_on             (cmd.silent),
        .i_table_address         (cmd.addr),
        .i_step_power            (cmd.power),
        .i_step_tone             (cmd.tone),
        .i_step_duration         (cmd.dur),
        .i_melody_silent_allowed (cmd.sil_ok),
        .o_out_valid             (o_out_valid),
        .i_out_ready             (out_ready),
        .o_buzzer_on             (o_buzzer_on),
        .o_tone_divider          (o_tone_divider),
        .o_sound_start           (o_sound_start),
        .o_sound_stop            (o_sound_stop),
        .o_playing               (o_playing),
        .o_silent_status         (o_silent_status)
    );

    initial begin
        forever #2 clk = ~clk;
    end

    function automatic t_resp play_step(input t_cmd c);
        t_resp      r;
        logic [7:0] a;
        r = '0;
        case (c.op)
            OP_TICK: begin
                pre_cnt = pre_cnt + 8'd1;
                if (pre_cnt >= tick_div) begin
                    pre_cnt = 8'd0;
                    if (time_left != 16'd0) time_left = time_left - 16'd1;
                end
                if (cur_mel == 5'd0) begin
                    r.stop    = 1'b1;
                    time_left = 16'd0;
                    step_ofs  = 8'd0;
                    buzz_now  = 1'b0;
                    tone_now  = 16'd0;
                end else if ((!silent_now || dir_mem[cur_mel].silent_ok)
                             && time_left == 16'd0) begin
                    a         = dir_mem[cur_mel].start + step_ofs;
                    buzz_now  = step_mem[a].power;
                    tone_now  = step_mem[a].tone;
                    time_left = step_mem[a].duration;
                    step_ofs  = step_ofs + 8'd1;
                    r.start   = 1'b1;
                    if (time_left == END_MARK) cur_mel = 5'd0;
                end
            end
            OP_PLAY: begin
                if (!silent_now || dir_mem[c.id].silent_ok) begin
                    cur_mel   = c.id;
                    step_ofs  = 8'd0;
                    time_left = 16'd0;
                end
            end
            OP_SET_SILENT: silent_now = c.silent;
            OP_LOAD_STEP: begin
                step_mem[c.addr].power    = c.power;
                step_mem[c.addr].tone     = c.tone;
                step_mem[c.addr].duration = c.dur;
            end
            OP_LOAD_DIR: begin
                dir_mem[c.id].start     = c.addr;
                dir_mem[c.id].silent_ok = c.sil_ok;
            end
            default: ;
        endcase
        r.buzz    = buzz_now;
        r.tone    = tone_now;
        r.playing = (cur_mel != 5'd0);
        r.silent  = silent_now;
        return r;
    endfunction

    task automatic check_field(input string name, input logic [15:0] want,
                               input logic [15:0] got);
        if (got !== want) begin
            $error("%s mismatch: expected %0h, got %0h", name, want, got);
            errors++;
        end
    endtask

    always @(posedge clk) begin
        t_resp want;
        bit    moved;
        moved = 1'b0;
        if (rst_n) begin
            if (o_out_valid && out_ready) begin
                moved = 1'b1;
                if (pending_outputs.size() == 0) begin
                    $error("result transaction with nothing pending");
                    errors++;
                end else begin
                    want = pending_outputs.pop_front();
                    check_field("buzzer_on", 16'(want.buzz), 16'(o_buzzer_on));
                    check_field("tone_divider", want.tone, o_tone_divider);
                    check_field("sound_start", 16'(want.start), 16'(o_sound_start));
                    check_field("sound_stop", 16'(want.stop), 16'(o_sound_stop));
                    check_field("playing", 16'(want.playing), 16'(o_playing));
                    check_field("silent_status", 16'(want.silent), 16'(o_silent_status));
                end
            end
            if (in_valid && o_in_ready) begin
                moved = 1'b1;
                want  = play_step(cmd);
                pending_outputs.push_back(cmd_typed ? cmd_exp : want);
            end
        end
        stall_cycles = moved ? 0 : stall_cycles + 1;
    end

    initial begin : watchdog
        do @(posedge clk); while (stall_cycles < WATCHDOG_LIMIT);
        $display("Verification failed");
        $finish;
    end

    initial begin : receiver
        while (!rst_n) @(posedge clk);
        forever begin
            if (hold_req) begin
                hold_req = 1'b0;
                out_ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge clk);
            end else if (rx_idle_en && $urandom_range(0, 3) == 0) begin
                out_ready <= 1'b0;
                repeat ($urandom_range(1, 16)) @(posedge clk);
            end else begin
                out_ready <= 1'b1;
                repeat ($urandom_range(1, 20)) @(posedge clk);
            end
        end
    end

    task automatic send_cmd(input t_cmd c, input logic typed = 1'b0,
                            input t_resp ex = '0);
        if (tx_idle_en && $urandom_range(0, 5) == 0) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 16)) @(posedge clk);
        end
        in_valid  <= 1'b1;
        cmd       <= c;
        cmd_typed <= typed;
        cmd_exp   <= ex;
        do @(posedge clk); while (!o_in_ready);
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending_outputs.size() != 0) @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic write_prescale(input logic [7:0] v);
        drain();
        cfg_we    <= 1'b1;
        cfg_wdata <= v;
        @(posedge clk);
        cfg_we    <= 1'b0;
        tick_div   = v;
    endtask

    function automatic logic [15:0] step_len();
        case ($urandom_range(0, 9))
            0, 1:    return END_MARK;
            2:       return 16'($urandom);
            3:       return 16'($urandom_range(5, 40));
            default: return 16'($urandom_range(0, 4));
        endcase
    endfunction

    function automatic t_cmd rand_cmd();
        t_cmd c;
        int   r;
        c.id     = 5'($urandom);
        c.silent = 1'($urandom);
        c.addr   = 8'($urandom);
        c.power  = 1'($urandom);
        c.tone   = 16'($urandom);
        c.dur    = step_len();
        c.sil_ok = 1'($urandom);
        r = $urandom_range(0, 99);
        if (r < 50)      c.op = OP_TICK;
        else if (r < 62) c.op = OP_PLAY;
        else if (r < 68) c.op = OP_SET_SILENT;
        else if (r < 80) c.op = OP_LOAD_STEP;
        else if (r < 88) c.op = OP_LOAD_DIR;
        else if (r < 90) c.op = 3'($urandom_range(OP_RSVD5, OP_RSVD7));
        else             c.op = OP_TICK;
        return c;
    endfunction

    function automatic t_cmd mk(input logic [2:0] op, input logic [4:0] id,
                                input logic silent, input logic [7:0] addr,
                                input logic power, input logic [15:0] tone,
                                input logic [15:0] dur, input logic sil_ok);
        t_cmd c;
        c = '{op, id, silent, addr, power, tone, dur, sil_ok};
        return c;
    endfunction

    function automatic t_resp rs(input logic buzz, input logic [15:0] tone,
                                 input logic start, input logic stop,
                                 input logic playing, input logic silent);
        t_resp r;
        r = '{buzz, tone, start, stop, playing, silent};
        return r;
    endfunction

    task automatic add_row(input t_cmd c, input logic typed, input t_resp ex);
        t_row r;
        r.cmd   = c;
        r.typed = typed;
        r.exp   = ex;
        directed_rows.push_back(r);
    endtask

    task automatic run_mix(input int n, input int hold_at);
        for (int i = 0; i < n; i++) begin
            if (i == hold_at) hold_req = 1'b1;
            send_cmd(rand_cmd());
        end
    endtask

    initial begin : main
        t_cmd c;
        tick_div   = PRESCALE_RESET;
        pre_cnt    = 8'd0;
        time_left  = 16'd0;
        step_ofs   = 8'd0;
        cur_mel    = 5'd0;
        buzz_now   = 1'b0;
        tone_now   = 16'd0;
        silent_now = 1'b0;

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // fill both stores so no playback ever reads an unwritten entry
        for (int a = 0; a < STEP_DEPTH_DEF; a++) begin
            c      = rand_cmd();
            c.op   = OP_LOAD_STEP;
            c.addr = 8'(a);
            send_cmd(c);
        end
        for (int d = 0; d < MELODY_COUNT_DEF; d++) begin
            c    = rand_cmd();
            c.op = OP_LOAD_DIR;
            c.id = 5'(d);
            send_cmd(c);
        end

        add_row(mk(OP_TICK, 0, 0, 0, 0, 0, 0, 0), 1'b1, rs(0, 0, 0, 1, 0, 0));
        add_row(mk(OP_RSVD5, 0, 0, 0, 0, 0, 0, 0), 1'b1, rs(0, 0, 0, 0, 0, 0));
        add_row(mk(OP_RSVD6, 5'd9, 1, 8'h55, 1, 16'hAAAA, 16'h5555, 1), 1'b1,
                rs(0, 0, 0, 0, 0, 0));
        add_row(mk(OP_RSVD7, 5'd31, 1, 8'hFF, 1, 16'hFFFF, 16'hFFFF, 1), 1'b1,
                rs(0, 0, 0, 0, 0, 0));
        add_row(mk(OP_SET_SILENT, 0, 1, 0, 0, 0, 0, 0), 1'b1, rs(0, 0, 0, 0, 0, 1));
        add_row(mk(OP_LOAD_DIR, 5'd3, 0, 8'hFF, 0, 0, 0, 0), 1'b1,
                rs(0, 0, 0, 0, 0, 1));
        // refused: silent and no permission
        add_row(mk(OP_PLAY, 5'd3, 0, 0, 0, 0, 0, 0), 1'b1, rs(0, 0, 0, 0, 0, 1));
        add_row(mk(OP_LOAD_DIR, 5'd31, 0, 8'h00, 0, 0, 0, 1), 1'b1,
                rs(0, 0, 0, 0, 0, 1));
        add_row(mk(OP_PLAY, 5'd31, 0, 0, 0, 0, 0, 0), 1'b1, rs(0, 0, 0, 0, 1, 1));
        add_row(mk(OP_TICK, 0, 0, 0, 0, 0, 0, 0), 1'b0, '0);
        add_row(mk(OP_SET_SILENT, 0, 0, 0, 0, 0, 0, 0), 1'b0, '0);
        add_row(mk(OP_LOAD_STEP, 0, 0, 8'hFF, 1, 16'hFFFF, END_MARK, 0), 1'b0, '0);
        add_row(mk(OP_PLAY, 5'd3, 0, 0, 0, 0, 0, 0), 1'b0, '0);
        add_row(mk(OP_TICK, 0, 0, 0, 0, 0, 0, 0), 1'b0, '0);
        add_row(mk(OP_TICK, 0, 0, 0, 0, 0, 0, 0), 1'b0, '0);
        add_row(mk(OP_LOAD_STEP, 0, 0, 8'h00, 1, 16'h1234, 16'd3, 0), 1'b0, '0);
        add_row(mk(OP_LOAD_DIR, 5'd3, 0, 8'h00, 0, 0, 0, 0), 1'b0, '0);
        add_row(mk(OP_PLAY, 5'd3, 0, 0, 0, 0, 0, 0), 1'b0, '0);
        add_row(mk(OP_TICK, 0, 0, 0, 0, 0, 0, 0), 1'b0, '0);
        // silenced mid-melody: output freezes
        add_row(mk(OP_SET_SILENT, 0, 1, 0, 0, 0, 0, 0), 1'b0, '0);
        add_row(mk(OP_TICK, 0, 0, 0, 0, 0, 0, 0), 1'b0, '0);
        add_row(mk(OP_TICK, 0, 0, 0, 0, 0, 0, 0), 1'b0, '0);
        add_row(mk(OP_SET_SILENT, 0, 0, 0, 0, 0, 0, 0), 1'b0, '0);
        add_row(mk(OP_PLAY, 5'd0, 0, 0, 0, 0, 0, 0), 1'b0, '0);
        add_row(mk(OP_TICK, 0, 0, 0, 0, 0, 0, 0), 1'b0, '0);

        foreach (directed_rows[i])
            send_cmd(directed_rows[i].cmd, directed_rows[i].typed,
                     directed_rows[i].exp);

        run_mix(250, 80);
        write_prescale(8'd0);
        run_mix(220, -1);
        write_prescale(8'd1);
        run_mix(220, -1);
        write_prescale(8'd255);
        run_mix(150, -1);
        write_prescale(8'($urandom_range(2, 254)));
        run_mix(220, -1);
        tx_idle_en = 1'b0;
        rx_idle_en = 1'b0;
        write_prescale(8'd3);
        run_mix(200, -1);

        drain();
        if (errors == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
